@@ design/i2cra_pkg.sv @@
package i2cra_pkg;

	localparam int HOLD_W = 10;
	localparam int SEG_W  = 4;
	localparam int OFF_W  = 5;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd100;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [SEG_W-1:0] WR_LAST_SEG = 4'd7;
	localparam logic [SEG_W-1:0] RD_LAST_SEG = 4'd11;

	typedef enum logic [2:0] {
		K_START = 3'd1,
		K_BYTE  = 3'd2,
		K_ACK   = 3'd3,
		K_RDPRE = 3'd4,
		K_RDBIT = 3'd5,
		K_NACK  = 3'd6,
		K_STOP  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		S_DEVW = 2'd0,
		S_DEVR = 2'd1,
		S_REG  = 2'd2,
		S_DATA = 2'd3
	} src_t;

	typedef struct packed {
		kind_t kind;
		src_t  src;
	} seg_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
		logic smp;
	} line_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} result_t;

	function automatic seg_t seq_at(input logic is_read, input logic [SEG_W-1:0] idx);
		seg_t s;
		s = '{kind: K_STOP, src: S_DEVW};
		if (!is_read) begin
			case (idx)
				4'd0: s = '{kind: K_START, src: S_DEVW};
				4'd1: s = '{kind: K_BYTE,  src: S_DEVW};
				4'd2: s = '{kind: K_ACK,   src: S_DEVW};
				4'd3: s = '{kind: K_BYTE,  src: S_REG};
				4'd4: s = '{kind: K_ACK,   src: S_DEVW};
				4'd5: s = '{kind: K_BYTE,  src: S_DATA};
				4'd6: s = '{kind: K_ACK,   src: S_DEVW};
				default: s = '{kind: K_STOP, src: S_DEVW};
			endcase
		end else begin
			case (idx)
				4'd0:  s = '{kind: K_START, src: S_DEVW};
				4'd1:  s = '{kind: K_BYTE,  src: S_DEVW};
				4'd2:  s = '{kind: K_ACK,   src: S_DEVW};
				4'd3:  s = '{kind: K_BYTE,  src: S_REG};
				4'd4:  s = '{kind: K_ACK,   src: S_DEVW};
				4'd5:  s = '{kind: K_START, src: S_DEVW};
				4'd6:  s = '{kind: K_BYTE,  src: S_DEVR};
				4'd7:  s = '{kind: K_ACK,   src: S_DEVW};
				4'd8:  s = '{kind: K_RDPRE, src: S_DEVW};
				4'd9:  s = '{kind: K_RDBIT, src: S_DEVW};
				4'd10: s = '{kind: K_NACK,  src: S_DEVW};
				default: s = '{kind: K_STOP, src: S_DEVW};
			endcase
		end
		return s;
	endfunction

	function automatic logic [OFF_W-1:0] last_off(input kind_t kind);
		logic [OFF_W-1:0] r;
		case (kind)
			K_START: r = 5'd3;
			K_BYTE:  r = 5'd31;
			K_ACK:   r = 5'd4;
			K_RDPRE: r = 5'd0;
			K_RDBIT: r = 5'd31;
			K_NACK:  r = 5'd2;
			default: r = 5'd3;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] byte_of(input src_t src, input logic [7:0] dev,
		input logic [7:0] regb, input logic [7:0] data);
		logic [7:0] r;
		case (src)
			S_DEVW:  r = {dev[7:1], 1'b0};
			S_DEVR:  r = {dev[7:1], 1'b1};
			S_REG:   r = regb;
			default: r = data;
		endcase
		return r;
	endfunction

	function automatic line_t decode(input seg_t seg, input logic [OFF_W-1:0] off,
		input logic [7:0] byte_val);
		line_t      l;
		logic [1:0] sub;
		logic [2:0] bit_idx;
		sub     = off[1:0];
		bit_idx = ~off[4:2];
		l       = '{scl: 1'b0, sda: 1'b0, drv: 1'b1, smp: 1'b0};
		case (seg.kind)
			K_START: begin
				l.scl = (off < 5'd3);
				l.sda = (off == 5'd0);
			end
			K_BYTE: begin
				l.sda = byte_val[bit_idx];
				l.scl = (sub inside {2'd1, 2'd2});
			end
			K_ACK: begin
				l.scl = (off inside {[5'd1:5'd3]});
				l.drv = (off == 5'd4);
			end
			K_RDPRE: begin
				l.drv = 1'b0;
			end
			K_RDBIT: begin
				l.scl = (sub inside {2'd1, 2'd2});
				l.drv = 1'b0;
				l.smp = (sub == 2'd1);
			end
			K_NACK: begin
				l.scl = (off == 5'd1);
				l.sda = (off < 5'd2);
			end
			default: begin
				l.scl = (off >= 5'd1);
				l.sda = (off == 5'd3);
			end
		endcase
		return l;
	endfunction

endpackage

@@ design/i2cra_if.sv @@
interface i2cra_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] device_address;
	logic [7:0] register_address;
	logic [7:0] write_data;
	logic       sda_in;

	modport source(output valid, action, device_address, register_address, write_data,
		sda_in, input ready);
	modport sink(input valid, action, device_address, register_address, write_data,
		sda_in, output ready);
endinterface

interface i2cra_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;

	modport source(output valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
		input ready);
	modport sink(input valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
		output ready);
endinterface

@@ design/i2cra_core.sv @@
module i2cra_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [1:0]                action,
	input  logic [7:0]                device_address,
	input  logic [7:0]                register_address,
	input  logic [7:0]                write_data,
	input  logic                      sda_in,
	input  logic                      cfg_we,
	input  logic [i2cra_pkg::HOLD_W-1:0] cfg_wdata,
	output i2cra_pkg::result_t        res
);
	import i2cra_pkg::*;

	logic [HOLD_W-1:0] phase_hold_q;
	logic              busy_q, busy_d;
	logic [SEG_W-1:0]  seg_q, seg_d;
	logic [OFF_W-1:0]  off_q, off_d;
	logic [HOLD_W-1:0] hold_q, hold_d;
	logic              is_read_q, is_read_d;
	logic [7:0]        dev_q, dev_d;
	logic [7:0]        reg_q, reg_d;
	logic [7:0]        data_q, data_d;
	logic [7:0]        rx_q, rx_d;
	logic              done;
	seg_t              cur_seg, new_seg;
	line_t             cur_line, new_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_hold_q <= HOLD_RESET;
		end else if (cfg_we) begin
			phase_hold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			seg_q     <= '0;
			off_q     <= '0;
			hold_q    <= '0;
			is_read_q <= 1'b0;
			dev_q     <= '0;
			reg_q     <= '0;
			data_q    <= '0;
			rx_q      <= '0;
		end else if (step) begin
			busy_q    <= busy_d;
			seg_q     <= seg_d;
			off_q     <= off_d;
			hold_q    <= hold_d;
			is_read_q <= is_read_d;
			dev_q     <= dev_d;
			reg_q     <= reg_d;
			data_q    <= data_d;
			rx_q      <= rx_d;
		end
	end

	always_comb begin
		cur_seg   = seq_at(is_read_q, seg_q);
		cur_line  = decode(cur_seg, off_q, byte_of(cur_seg.src, dev_q, reg_q, data_q));
		busy_d    = busy_q;
		seg_d     = seg_q;
		off_d     = off_q;
		hold_d    = hold_q;
		is_read_d = is_read_q;
		dev_d     = dev_q;
		reg_d     = reg_q;
		data_d    = data_q;
		rx_d      = rx_q;
		done      = 1'b0;
		if (!busy_q) begin
			if (action == ACT_WRITE || action == ACT_READ) begin
				is_read_d = (action == ACT_READ);
				dev_d     = device_address;
				reg_d     = register_address;
				data_d    = write_data;
				busy_d    = 1'b1;
				seg_d     = '0;
				off_d     = '0;
				hold_d    = HOLD_W'(1);
			end
		end else if (hold_q >= phase_hold_q) begin
			if (cur_line.smp) begin
				rx_d = {rx_q[6:0], sda_in};
			end
			hold_d = HOLD_W'(1);
			if (off_q == last_off(cur_seg.kind)) begin
				off_d = '0;
				if (seg_q == (is_read_q ? RD_LAST_SEG : WR_LAST_SEG)) begin
					busy_d = 1'b0;
					seg_d  = '0;
					hold_d = '0;
					done   = 1'b1;
				end else begin
					seg_d = seg_q + SEG_W'(1);
				end
			end else begin
				off_d = off_q + OFF_W'(1);
			end
		end else begin
			hold_d = hold_q + HOLD_W'(1);
		end

		new_seg  = seq_at(is_read_d, seg_d);
		new_line = decode(new_seg, off_d, byte_of(new_seg.src, dev_d, reg_d, data_d));
		if (busy_d) begin
			res.scl       = new_line.scl;
			res.sda_out   = new_line.drv & new_line.sda;
			res.sda_drive = new_line.drv;
		end else begin
			res.scl       = 1'b1;
			res.sda_out   = 1'b1;
			res.sda_drive = 1'b1;
		end
		res.busy_res  = busy_d;
		res.done_res  = done;
		res.read_data = rx_d;
	end

endmodule

@@ design/i2c_register_access_master_unit.sv @@
// I2C master for one single-register write or read.
// req channel: one beat per tick; action selects tick only, start write or
// start read, with the device, register and data bytes and the sampled SDA.
// A start is taken only while idle; otherwise the beat is a plain tick.
// rsp channel: one beat per req beat, in order, carrying the SCL/SDA line
// levels, SDA drive enable, busy, the done pulse and the read byte.
// Latency: a req beat's response is valid on the next cycle.
// Throughput: one beat per cycle, set by the single state update and the
// output register; req.ready stays high while the output register is
// empty or being taken.
// Each line state lasts phase_hold ticks, or one if 0 (cfg_we/cfg_wdata,
// reset 100); a write takes 119 line states, a read 159.
// Reset: idle, lines high and driven, phase_hold back to 100, no rsp beat
// pending. When rsp stalls, the pending beat holds and req.ready drops
// until it is taken.
module i2c_register_access_master_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [i2cra_pkg::HOLD_W-1:0] cfg_wdata,
	i2cra_req_if.sink                    req,
	i2cra_rsp_if.source                  rsp
);
	import i2cra_pkg::*;

	logic    out_valid_q;
	result_t out_q;
	result_t res;
	logic    step;

	assign req.ready = !out_valid_q || rsp.ready;
	assign step      = req.valid && req.ready;

	i2cra_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.action           (req.action),
		.device_address   (req.device_address),
		.register_address (req.register_address),
		.write_data       (req.write_data),
		.sda_in           (req.sda_in),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.ready) begin
			out_valid_q <= req.valid;
		end
	end

	// hold the beat while rsp stalls
	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.scl       = out_q.scl;
	assign rsp.sda_out   = out_q.sda_out;
	assign rsp.sda_drive = out_q.sda_drive;
	assign rsp.busy_res  = out_q.busy_res;
	assign rsp.done_res  = out_q.done_res;
	assign rsp.read_data = out_q.read_data;

endmodule

@@ design/i2cra_checker.sv @@
module i2cra_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic scl,
	input logic sda_out,
	input logic sda_drive,
	input logic busy_res,
	input logic done_res
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp beat dropped while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> !busy_res)
		else $error("done pulse while still busy");

	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !busy_res |-> scl && sda_out && sda_drive)
		else $error("lines not released high while idle");

	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !sda_drive |-> !sda_out)
		else $error("sda_out high while SDA released");

endmodule

bind i2c_register_access_master_unit i2cra_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.scl       (rsp.scl),
	.sda_out   (rsp.sda_out),
	.sda_drive (rsp.sda_drive),
	.busy_res  (rsp.busy_res),
	.done_res  (rsp.done_res)
);

@@ verif/tb_i2c_register_access_master_unit.sv @@
`timescale 1ns / 100ps

module tb_i2c_register_access_master_unit;
	import i2cra_pkg::*;

	localparam int WR_SLOTS        = 119;
	localparam int RD_SLOTS        = 159;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int QUIET_LIMIT     = 4000;
	localparam int MAX_REPORTS     = 30;

	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] dev;
		logic [7:0] regb;
		logic [7:0] data;
		logic       sda;
	} req_beat_t;

	typedef struct packed {
		logic ok;
		logic scl;
		logic sda;
		logic drv;
		logic smp;
	} bus_level_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [HOLD_W-1:0] cfg_wdata = '0;

	req_beat_t offer = '0;
	logic      offer_valid = 1'b0;
	logic      rsp_ready_q = 1'b0;

	i2cra_req_if req_bus ();
	i2cra_rsp_if rsp_bus ();

	assign req_bus.valid            = offer_valid;
	assign req_bus.action           = offer.action;
	assign req_bus.device_address   = offer.dev;
	assign req_bus.register_address = offer.regb;
	assign req_bus.write_data       = offer.data;
	assign req_bus.sda_in           = offer.sda;
	assign rsp_bus.ready            = rsp_ready_q;

	i2c_register_access_master_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// bus state mirror
	logic [7:0]        bus_pos  = '0;
	logic [HOLD_W-1:0] bus_hc   = '0;
	logic [HOLD_W-1:0] bus_hold = HOLD_RESET;
	logic              bus_rd   = 1'b0;
	logic [7:0]        bus_dev  = '0;
	logic [7:0]        bus_reg  = '0;
	logic [7:0]        bus_dat  = '0;
	logic [7:0]        bus_rx   = '0;

	req_beat_t pending_beats [$];
	result_t   expected_lines [$];

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int holdoffs_asked  = 0;
	int holdoffs_done   = 0;
	int stall_left      = 0;
	int quiet_cycles    = 0;
	int beats_checked   = 0;
	int mismatches      = 0;
	int stray_results   = 0;
	int writes_done     = 0;
	int reads_done      = 0;
	int settings_used   = 1;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic kind_t seg_kind(input logic rd, input int idx);
		kind_t k;
		k = K_STOP;
		case (idx)
			0: k = K_START;
			1: k = K_BYTE;
			2: k = K_ACK;
			3: k = K_BYTE;
			4: k = K_ACK;
			default: k = K_STOP;
		endcase
		if (idx > 4) begin
			if (rd) begin
				case (idx)
					5:  k = K_START;
					6:  k = K_BYTE;
					7:  k = K_ACK;
					8:  k = K_RDPRE;
					9:  k = K_RDBIT;
					10: k = K_NACK;
					default: k = K_STOP;
				endcase
			end else begin
				case (idx)
					5: k = K_BYTE;
					6: k = K_ACK;
					default: k = K_STOP;
				endcase
			end
		end
		return k;
	endfunction

	function automatic int seg_len(input kind_t k);
		int n;
		case (k)
			K_START: n = 4;
			K_BYTE:  n = 32;
			K_ACK:   n = 5;
			K_RDPRE: n = 1;
			K_RDBIT: n = 32;
			K_NACK:  n = 3;
			default: n = 4;
		endcase
		return n;
	endfunction

	function automatic bus_level_t slot_level(input logic [7:0] pos);
		bus_level_t lv;
		int         k;
		int         i;
		int         n;
		int         len;
		kind_t      kind;
		logic [7:0] byte_v;
		logic [1:0] sub;
		lv     = '0;
		lv.drv = 1'b1;
		if (pos == 8'd0)
			return lv;
		k    = int'(pos) - 1;
		n    = bus_rd ? 12 : 8;
		kind = K_STOP;
		for (i = 0; i < n; i++) begin
			kind = seg_kind(bus_rd, i);
			len  = seg_len(kind);
			if (k < len)
				break;
			k -= len;
		end
		if (i >= n)
			return lv;
		lv.ok  = 1'b1;
		sub    = k[1:0];
		byte_v = (i == 1) ? {bus_dev[7:1], 1'b0} :
			(i == 3) ? bus_reg :
			(bus_rd ? {bus_dev[7:1], 1'b1} : bus_dat);
		case (kind)
			K_START: begin
				lv.scl = (k < 3);
				lv.sda = (k == 0);
			end
			K_BYTE: begin
				lv.sda = byte_v[7 - (k >> 2)];
				lv.scl = (sub == 2'd1 || sub == 2'd2);
			end
			K_ACK: begin
				lv.scl = (k >= 1 && k <= 3);
				lv.drv = (k == 4);
			end
			K_RDPRE: begin
				lv.drv = 1'b0;
			end
			K_RDBIT: begin
				lv.scl = (sub == 2'd1 || sub == 2'd2);
				lv.drv = 1'b0;
				lv.smp = (sub == 2'd1);
			end
			K_NACK: begin
				lv.scl = (k == 1);
				lv.sda = (k < 2);
			end
			default: begin
				lv.scl = (k >= 1);
				lv.sda = (k == 3);
			end
		endcase
		return lv;
	endfunction

	task automatic step_bus(input req_beat_t b, output result_t r);
		bus_level_t lv;
		logic       done;
		done = 1'b0;
		if (bus_pos == 8'd0) begin
			if (b.action == ACT_WRITE || b.action == ACT_READ) begin
				bus_rd  = (b.action == ACT_READ);
				bus_dev = b.dev;
				bus_reg = b.regb;
				bus_dat = b.data;
				bus_pos = 8'd1;
				bus_hc  = HOLD_W'(1);
			end
		end else if (bus_hc >= bus_hold) begin
			lv = slot_level(bus_pos);
			if (lv.smp)
				bus_rx = {bus_rx[6:0], b.sda};
			bus_pos = bus_pos + 8'd1;
			bus_hc  = HOLD_W'(1);
			lv = slot_level(bus_pos);
			if (!lv.ok) begin
				bus_pos = 8'd0;
				bus_hc  = '0;
				done    = 1'b1;
				if (bus_rd)
					reads_done++;
				else
					writes_done++;
			end
		end else begin
			bus_hc = bus_hc + 1'b1;
		end
		lv = slot_level(bus_pos);
		if (bus_pos == 8'd0) begin
			r.scl       = 1'b1;
			r.sda_out   = 1'b1;
			r.sda_drive = 1'b1;
		end else begin
			r.scl       = lv.scl;
			r.sda_out   = lv.drv ? lv.sda : 1'b0;
			r.sda_drive = lv.drv;
		end
		r.busy_res  = (bus_pos != 8'd0);
		r.done_res  = done;
		r.read_data = bus_rx;
	endtask

	task automatic add_beat(input logic [1:0] act, input logic [7:0] dev,
		input logic [7:0] regb, input logic [7:0] data, input logic sda);
		req_beat_t b;
		b.action = act;
		b.dev    = dev;
		b.regb   = regb;
		b.data   = data;
		b.sda    = sda;
		pending_beats.push_back(b);
	endtask

	task automatic add_random_beat(input logic [1:0] act);
		add_beat(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// mostly whole transactions with busy-time noise, a few random bursts
	task automatic queue_traffic(input int n);
		int         left;
		int         span;
		int         t;
		int         h;
		logic [1:0] act;
		left = n;
		h    = (bus_hold == 0) ? 1 : int'(bus_hold);
		while (left > 0) begin
			if ($urandom_range(0, 99) < 80) begin
				act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
				add_random_beat(act);
				left--;
				span = ((act == ACT_READ) ? RD_SLOTS : WR_SLOTS) * h - 1 + $urandom_range(0, 3);
				for (t = 0; t < span && left > 0; t++) begin
					if ($urandom_range(0, 99) < 8)
						add_random_beat(2'($urandom_range(0, 3)));
					else
						add_random_beat(ACT_TICK);
					left--;
				end
			end else begin
				span = $urandom_range(1, 20);
				for (t = 0; t < span && left > 0; t++) begin
					add_random_beat(2'($urandom_range(0, 3)));
					left--;
				end
			end
		end
	endtask

	task automatic set_phase_hold(input logic [HOLD_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		bus_hold = v;
	endtask

	task automatic wait_drained;
		while (pending_beats.size() != 0 || offer_valid || expected_lines.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_req
		result_t   r;
		req_beat_t b;
		if (!arst_n) begin
			offer_valid <= 1'b0;
			offer       <= '0;
		end else begin
			if (offer_valid && req_bus.ready) begin
				step_bus(offer, r);
				expected_lines.push_back(r);
			end
			if (!offer_valid || req_bus.ready) begin
				if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					b = pending_beats.pop_front();
					offer_valid <= 1'b1;
					offer       <= b;
				end else begin
					offer_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_rsp
		result_t want;
		if (!arst_n) begin
			rsp_ready_q <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_lines.size() == 0) begin
					stray_results++;
					if (stray_results <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected, scl %0b busy %0b",
							$time, rsp_bus.scl, rsp_bus.busy_res);
				end else begin
					want = expected_lines.pop_front();
					beats_checked++;
					check_field("scl", int'(want.scl), int'(rsp_bus.scl));
					check_field("sda_out", int'(want.sda_out), int'(rsp_bus.sda_out));
					check_field("sda_drive", int'(want.sda_drive), int'(rsp_bus.sda_drive));
					check_field("busy_res", int'(want.busy_res), int'(rsp_bus.busy_res));
					check_field("done_res", int'(want.done_res), int'(rsp_bus.done_res));
					check_field("read_data", int'(want.read_data), int'(rsp_bus.read_data));
				end
			end
			// hold off for a long stretch on request, else stall at random
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				rsp_ready_q <= 1'b0;
			end else if (holdoffs_done != holdoffs_asked) begin
				holdoffs_done = holdoffs_done + 1;
				stall_left = HOLD_OFF_CYCLES;
				rsp_ready_q <= 1'b0;
			end else begin
				rsp_ready_q <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : run_phases
		int hold_set [6];
		int beat_set [6];
		int send_set [6];
		int recv_set [6];
		int p;
		int i;
		hold_set = '{1, 2, 0, 1023, 3, 1};
		beat_set = '{300, 250, 200, 120, 300, 180};
		send_set = '{0, 70, 0, 6, 6, 0};
		recv_set = '{0, 0, 70, 6, 6, 0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks, a start with extreme bytes, then requests while busy
		add_beat(ACT_SPARE, 8'hAA, 8'h55, 8'hAA, 1'b1);
		add_beat(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b1);
		add_beat(ACT_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b0);
		add_beat(ACT_READ, 8'h00, 8'hFF, 8'h00, 1'b1);
		add_beat(ACT_WRITE, 8'h01, 8'h80, 8'h7F, 1'b0);
		add_beat(ACT_SPARE, 8'hFE, 8'h01, 8'h80, 1'b1);
		for (i = 0; i < 19; i++)
			add_beat(ACT_TICK, 8'h00, 8'hFF, 8'h00, i[0]);
		wait_drained();

		for (p = 0; p < 6; p++) begin
			set_phase_hold(HOLD_W'(hold_set[p]));
			settings_used++;
			send_idle_pct  = send_set[p];
			recv_stall_pct = recv_set[p];
			queue_traffic(beat_set[p]);
			if (p == 4)
				holdoffs_asked++;
			wait_drained();
		end
		repeat (8) @(posedge clk);

		$display("Checked %0d result beats over %0d hold phases (0, 1, 2, 3, 100, 1023).",
			beats_checked, settings_used);
		$display("Transactions completed: %0d writes, %0d reads.", writes_done, reads_done);
		if (mismatches == 0 && stray_results == 0 && expected_lines.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
